// ----- sv/sst_pkg.sv -----
// shared constants and types for the sorted set table
package sst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int CMD_W = 2;
  localparam int IN_W = 40;
  localparam int OUT_W = 8;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // broadcast control to every cell
  typedef struct packed {
    logic insert_en;
    logic delete_en;
  } cell_ctrl_t;

  // per-cell compare status
  typedef struct packed {
    logic below;
    logic hit;
  } cell_stat_t;

endpackage

// ----- sv/sorted_set_table.sv -----
// top level of the sorted set table: a row of compare-and-shift cells
//
//  channel  dir  fields (tdata, lowest bit up)
//  s_*      in   command[1:0], value[33:2], zero pad [39:34]
//  m_*      out  found[0], full_res[1], entry_count[6:2], zero pad [7]
//
// one request per cycle while s_tready is high: every cell compares its entry
// with the broadcast value and shifts toward its neighbor in the same cycle, so
// the row updates at the edge the request is accepted; the result shows in the
// next cycle. reset clears the entry count and the output valid flag; cells
// have no reset, and cells above the count are never read. s_tready drops only
// while a result waits in the output register and m_tready is low.
module sorted_set_table
  import sst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command[1:0], value[33:2]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // found[0], full_res[1], entry_count[6:2]
);

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CNT_W+4:0]        count_ext;
  logic                    accept;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;
  logic                    hit;
  logic                    full;
  logic                    full_res;
  cell_ctrl_t              ctrl;
  logic [OUT_W-1:0]        res_data;

  logic signed [KEY_W-1:0] entries [TABLE_DEPTH];
  cell_stat_t              stats   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  occ;
  logic [TABLE_DEPTH-1:0]  hits;

  assign cmd    = s_tdata[CMD_W-1:0];
  assign key    = s_tdata[CMD_W+KEY_W-1:CMD_W];
  assign accept = s_tvalid && s_tready;

  // occupancy and hit vectors
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      occ[i]  = ({1'b0, CNT_W'(i)} < {1'b0, count});
      hits[i] = stats[i].hit;
    end
  end

  assign hit  = |hits;
  assign full = (count >= CNT_W'(TABLE_DEPTH));

  // broadcast control
  assign ctrl.insert_en = accept && (cmd == CMD_INSERT) && !hit && !full;
  assign ctrl.delete_en = accept && (cmd == CMD_DELETE) && hit;
  assign full_res       = (cmd == CMD_INSERT) && !hit && full;

  // the row of cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                    l_occ;
    logic                    l_below;
    logic signed [KEY_W-1:0] l_entry;
    logic                    r_occ;
    logic signed [KEY_W-1:0] r_entry;

    if (g == 0) begin : g_first
      assign l_occ   = 1'b1;
      assign l_below = 1'b1;
      assign l_entry = key;
    end else begin : g_mid
      assign l_occ   = occ[g-1];
      assign l_below = stats[g-1].below;
      assign l_entry = entries[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign r_occ   = 1'b0;
      assign r_entry = entries[g];
    end else begin : g_inner
      assign r_occ   = occ[g+1];
      assign r_entry = entries[g+1];
    end

    sst_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .occ         (occ[g]),
      .left_occ    (l_occ),
      .left_below  (l_below),
      .left_entry  (l_entry),
      .right_occ   (r_occ),
      .right_entry (r_entry),
      .entry       (entries[g]),
      .stat        (stats[g])
    );
  end

  // entry count
  always_comb begin
    count_next = count;
    if (ctrl.insert_en) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.delete_en) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result packing
  assign count_ext = {5'b0, count_next};
  assign res_data  = {1'b0, count_ext[4:0], full_res, hit};

  sst_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .data     (res_data),
    .can_load (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- sv/sst_cell.sv -----
// one table cell: holds an entry, compares against the key, shifts with neighbors
module sst_cell
  import sst_pkg::*;
(
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [KEY_W-1:0] key,
  input  logic                    occ,
  input  logic                    left_occ,
  input  logic                    left_below,
  input  logic signed [KEY_W-1:0] left_entry,
  input  logic                    right_occ,
  input  logic signed [KEY_W-1:0] right_entry,
  output logic signed [KEY_W-1:0] entry,
  output cell_stat_t              stat
);

  logic shift_up;
  logic is_place;
  logic signed [KEY_W-1:0] entry_next;

  // compare against the broadcast key
  assign stat.below = occ && (entry < key);
  assign stat.hit   = occ && (entry == key);

  // position relative to the insertion point
  assign shift_up = left_occ && !left_below;
  assign is_place = left_below && !stat.below;

  // next entry: shift up on insert, shift down on delete
  always_comb begin
    entry_next = entry;
    if (ctrl.insert_en) begin
      if (is_place) begin
        entry_next = key;
      end else if (shift_up) begin
        entry_next = left_entry;
      end
    end else if (ctrl.delete_en) begin
      if (right_occ && !stat.below) begin
        entry_next = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- sv/sst_out_reg.sv -----
// output register for results, decouples the result side from the request side
module sst_out_reg
  import sst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [OUT_W-1:0] data,
  output logic             can_load,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  assign can_load = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= data;
    end
  end

endmodule
